/* rtl/kaf_pkg.sv */
// ----------------------------------------------------------------------------
// kaf_pkg: shared types and constants of the angle kalman filter
// fixed point format, register map, sequencer states and unit opcodes
// ----------------------------------------------------------------------------
`default_nettype none

package kaf_pkg;

  localparam int DataWidthDef = 48;
  localparam int FracBitsDef  = 32;

  // register indexes on the configuration port
  localparam logic [1:0] RegQAngle = 2'd0;
  localparam logic [1:0] RegQBias  = 2'd1;
  localparam logic [1:0] RegRMeas  = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_RATE,      // rate = w - bias
    ST_MDR,       // m = dt*rate
    ST_ANG1,      // ang += m
    ST_T1,        // t = dt*p11
    ST_T2,        // t -= p01
    ST_T3,        // t -= p10
    ST_T4,        // t += q_angle
    ST_T5,        // m = dt*t
    ST_P00A,      // p00 += m
    ST_D,         // d = dt*p11
    ST_P01A,      // p01 -= d
    ST_P10A,      // p10 -= d
    ST_QB,        // m = q_bias*dt
    ST_P11A,      // p11 += m
    ST_S,         // s = p00 + r
    ST_K0,        // k0 = p00/s
    ST_K1,        // k1 = p10/s
    ST_GAP,       // gap = z - ang
    ST_M1,        // m = k0*gap
    ST_ANG2,
    ST_M2,        // m = k1*gap
    ST_BIAS,
    ST_M3,        // m = k0*p00
    ST_M4,        // t = k0*p01
    ST_M5,        // gap = k1*p00
    ST_M6,        // k0 = k1*p01
    ST_P00B,
    ST_P01B,
    ST_P10B,
    ST_P11B,
    ST_OUT
  } seq_state_e;

endpackage

`default_nettype wire

/* rtl/kaf_alu.sv */
// ----------------------------------------------------------------------------
// kaf_alu: shared saturating arithmetic unit
// add and subtract without leaving idle, multiply over four partial products,
// divide one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module kaf_alu
  import kaf_pkg::*;
#(
  parameter int DataWidth = DataWidthDef,
  parameter int FracBits  = FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire alu_op_e                     op_i,
  input  wire logic signed [DataWidth-1:0] a_i,
  input  wire logic signed [DataWidth-1:0] b_i,
  output logic                             done_o,
  output logic signed [DataWidth-1:0]      res_o,
  output logic                             sat_o
);

  localparam int HalfW = (DataWidth + 1) / 2;
  localparam int ProdW = 2 * DataWidth;
  localparam int QuoW  = DataWidth + FracBits;
  localparam int CntW  = $clog2(QuoW + 1);

  localparam logic signed [DataWidth-1:0] VMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] VMin = {1'b1, {(DataWidth-1){1'b0}}};

  typedef enum logic [1:0] {
    AU_IDLE,
    AU_MUL,
    AU_DIV,
    AU_FIN
  } alu_state_e;

  alu_state_e state_q, state_d;
  logic [1:0]            pp_q, pp_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic [DataWidth-1:0]  x_q, x_d, y_q, y_d;
  logic [ProdW-1:0]      acc_q, acc_d;
  logic [QuoW-1:0]       num_q, num_d;
  logic [QuoW-1:0]       quo_q, quo_d;
  logic [DataWidth:0]    rem_q, rem_d;
  logic                  done_q, done_d;
  logic signed [DataWidth-1:0] res_q, res_d;
  logic                  sat_q, sat_d;

  logic [DataWidth-1:0]  mag_a, mag_b;
  logic signed [DataWidth:0] sum_w;
  logic [HalfW-1:0]      xs, ys;
  logic [2*HalfW-1:0]    pp;
  logic [ProdW-1:0]      pp_sh;
  logic [DataWidth:0]    rem_sh;
  logic [ProdW-1:0]      pq;
  logic                  inexact;
  logic [ProdW-1:0]      mag_fin;

  assign mag_a = a_i[DataWidth-1] ? DataWidth'(-a_i) : a_i;
  assign mag_b = b_i[DataWidth-1] ? DataWidth'(-b_i) : b_i;

  assign xs = pp_q[0] ? HalfW'(x_q >> HalfW) : HalfW'(x_q);
  assign ys = pp_q[1] ? HalfW'(y_q >> HalfW) : HalfW'(y_q);
  assign pp = xs * ys;
  assign pp_sh = ProdW'(pp) << (HalfW * (int'(pp_q[0]) + int'(pp_q[1])));

  assign rem_sh = {rem_q[DataWidth-1:0], num_q[QuoW-1]};

  // product magnitude scaled down, floor for negatives
  assign pq = acc_q >> FracBits;
  assign inexact = |(acc_q & ((ProdW'(1) << FracBits) - ProdW'(1)));

  always_comb begin
    if (state_q == AU_FIN && cnt_q == '0) begin
      mag_fin = pq + ProdW'(neg_q && inexact);
    end else begin
      mag_fin = ProdW'(quo_q);
    end
  end

  always_comb begin
    state_d = state_q;
    pp_d = pp_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    x_d = x_q;
    y_d = y_q;
    acc_d = acc_q;
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    done_d = 1'b0;
    res_d = res_q;
    sat_d = sat_q;
    sum_w = '0;
    case (state_q)
      AU_IDLE: begin
        if (start_i) begin
          neg_d = a_i[DataWidth-1] ^ b_i[DataWidth-1];
          x_d = mag_a;
          y_d = mag_b;
          acc_d = '0;
          pp_d = '0;
          case (op_i)
            OP_ADD, OP_SUB: begin
              if (op_i == OP_ADD) begin
                sum_w = {a_i[DataWidth-1], a_i} + {b_i[DataWidth-1], b_i};
              end else begin
                sum_w = {a_i[DataWidth-1], a_i} - {b_i[DataWidth-1], b_i};
              end
              done_d = 1'b1;
              if (sum_w[DataWidth] != sum_w[DataWidth-1]) begin
                sat_d = 1'b1;
                res_d = sum_w[DataWidth] ? VMin : VMax;
              end else begin
                sat_d = 1'b0;
                res_d = sum_w[DataWidth-1:0];
              end
            end
            OP_MUL: begin
              state_d = AU_MUL;
            end
            OP_DIV: begin
              if (mag_b == '0) begin
                done_d = 1'b1;
                res_d = '0;
                sat_d = 1'b0;
              end else begin
                state_d = AU_DIV;
                num_d = QuoW'(mag_a) << FracBits;
                quo_d = '0;
                rem_d = '0;
                cnt_d = CntW'(QuoW);
              end
            end
            default: ;
          endcase
        end
      end
      AU_MUL: begin
        acc_d = acc_q + pp_sh;
        pp_d = pp_q + 2'd1;
        if (pp_q == 2'd3) begin
          state_d = AU_FIN;
          cnt_d = '0;
        end
      end
      AU_DIV: begin
        num_d = num_q << 1;
        if (rem_sh >= {1'b0, y_q}) begin
          rem_d = rem_sh - {1'b0, y_q};
          quo_d = {quo_q[QuoW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[QuoW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = AU_FIN;
          cnt_d = CntW'(1);
        end
      end
      AU_FIN: begin
        state_d = AU_IDLE;
        done_d = 1'b1;
        if (neg_q) begin
          if (mag_fin > (ProdW'(1) << (DataWidth - 1))) begin
            sat_d = 1'b1;
            res_d = VMin;
          end else begin
            sat_d = 1'b0;
            res_d = DataWidth'(-mag_fin);
          end
        end else begin
          if (mag_fin > ProdW'(VMax)) begin
            sat_d = 1'b1;
            res_d = VMax;
          end else begin
            sat_d = 1'b0;
            res_d = DataWidth'(mag_fin);
          end
        end
      end
      default: state_d = AU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AU_IDLE;
      done_q <= 1'b0;
      pp_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
      pp_q <= pp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    x_q <= x_d;
    y_q <= y_d;
    acc_q <= acc_d;
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

/* rtl/kalman_angle_filter.sv */
// ----------------------------------------------------------------------------
// kalman_angle_filter: two-state angle and rate-bias kalman filter
// sequencer driving one shared saturating add, multiply and divide unit
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// input    | in_valid_i/ready_o   | measured_angle, measured_rate, time_step,
//          |                      | force_angle
// output   | out_valid_o/ready_i  | filtered_angle, saturated
// config   | apb write/read       | process_noise_angle/bias, measurement_noise
//
// a filter step runs 30 unit operations in sequence; the divides are the slowest,
// and both are skipped when the innovation variance is zero.
// a forced angle skips the sequence and goes straight to the output register.
// reset clears state and loads the default noise values.
// the input is not ready while a step runs; a finished step holds until the
// output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_angle_filter
  import kaf_pkg::*;
#(
  parameter int DataWidth = DataWidthDef,
  parameter int FracBits  = FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [4:0]                  paddr,
  input  wire logic [63:0]                 pwdata,
  output logic [63:0]                      prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [DataWidth-1:0] measured_angle_i,
  input  wire logic signed [DataWidth-1:0] measured_rate_i,
  input  wire logic [DataWidth-2:0]        time_step_i,
  input  wire logic                        force_angle_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [DataWidth-1:0]      filtered_angle_o,
  output logic                             saturated_o
);

  localparam logic [DataWidth-2:0] QAngleRst =
    (DataWidth-1)'(((64'd1 << FracBits) + 64'd500) / 64'd1000);
  localparam logic [DataWidth-2:0] QBiasRst =
    (DataWidth-1)'(((64'd3 << FracBits) + 64'd500) / 64'd1000);
  localparam logic [DataWidth-2:0] RMeasRst =
    (DataWidth-1)'(((64'd3 << FracBits) + 64'd50) / 64'd100);

  typedef logic signed [DataWidth-1:0] val_t;

  logic [DataWidth-2:0] q_angle_q, q_bias_q, r_meas_q;
  val_t ang_q, ang_d, bias_q, bias_d;
  val_t p00_q, p00_d, p01_q, p01_d, p10_q, p10_d, p11_q, p11_d;
  val_t z_q, z_d, w_q, w_d, dt_q, dt_d;
  val_t tmp_q, tmp_d, m_q, m_d, k0_q, k0_d, k1_q, k1_d, gap_q, gap_d;
  logic sat_q, sat_d, busy_q, busy_d, out_valid_q, out_valid_d;
  val_t out_q, out_d;
  logic out_sat_q, out_sat_d;
  seq_state_e state_q, state_d;

  logic    alu_start;
  alu_op_e alu_op;
  val_t    alu_a, alu_b, alu_res;
  logic    alu_done, alu_sat;
  logic [1:0] reg_idx;
  logic    wr_en;

  kaf_alu #(
    .DataWidth(DataWidth),
    .FracBits (FracBits)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(alu_start),
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res),
    .sat_o  (alu_sat)
  );

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      RegQAngle: prdata = 64'(q_angle_q);
      RegQBias:  prdata = 64'(q_bias_q);
      RegRMeas:  prdata = 64'(r_meas_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_angle_q <= QAngleRst;
      q_bias_q <= QBiasRst;
      r_meas_q <= RMeasRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegQAngle: q_angle_q <= pwdata[DataWidth-2:0];
        RegQBias:  q_bias_q <= pwdata[DataWidth-2:0];
        RegRMeas:  r_meas_q <= pwdata[DataWidth-2:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign filtered_angle_o = out_q;
  assign saturated_o = out_sat_q;

  always_comb begin
    state_d = state_q;
    ang_d = ang_q; bias_d = bias_q;
    p00_d = p00_q; p01_d = p01_q; p10_d = p10_q; p11_d = p11_q;
    z_d = z_q; w_d = w_q; dt_d = dt_q;
    tmp_d = tmp_q; m_d = m_q; k0_d = k0_q; k1_d = k1_q; gap_d = gap_q;
    sat_d = sat_q;
    busy_d = busy_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    out_sat_d = out_sat_q;
    alu_start = 1'b0;
    alu_op = OP_ADD;
    alu_a = '0;
    alu_b = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // operand select per step
    case (state_q)
      ST_RATE: begin alu_op = OP_SUB; alu_a = w_q;   alu_b = bias_q; end
      ST_MDR:  begin alu_op = OP_MUL; alu_a = dt_q;  alu_b = tmp_q;  end
      ST_ANG1: begin alu_op = OP_ADD; alu_a = ang_q; alu_b = m_q;    end
      ST_T1:   begin alu_op = OP_MUL; alu_a = dt_q;  alu_b = p11_q;  end
      ST_T2:   begin alu_op = OP_SUB; alu_a = tmp_q; alu_b = p01_q;  end
      ST_T3:   begin alu_op = OP_SUB; alu_a = tmp_q; alu_b = p10_q;  end
      ST_T4:   begin alu_op = OP_ADD; alu_a = tmp_q; alu_b = val_t'({1'b0, q_angle_q}); end
      ST_T5:   begin alu_op = OP_MUL; alu_a = dt_q;  alu_b = tmp_q;  end
      ST_P00A: begin alu_op = OP_ADD; alu_a = p00_q; alu_b = m_q;    end
      ST_D:    begin alu_op = OP_MUL; alu_a = dt_q;  alu_b = p11_q;  end
      ST_P01A: begin alu_op = OP_SUB; alu_a = p01_q; alu_b = tmp_q;  end
      ST_P10A: begin alu_op = OP_SUB; alu_a = p10_q; alu_b = tmp_q;  end
      ST_QB:   begin alu_op = OP_MUL; alu_a = val_t'({1'b0, q_bias_q}); alu_b = dt_q; end
      ST_P11A: begin alu_op = OP_ADD; alu_a = p11_q; alu_b = m_q;    end
      ST_S:    begin alu_op = OP_ADD; alu_a = p00_q; alu_b = val_t'({1'b0, r_meas_q}); end
      ST_K0:   begin alu_op = OP_DIV; alu_a = p00_q; alu_b = tmp_q;  end
      ST_K1:   begin alu_op = OP_DIV; alu_a = p10_q; alu_b = tmp_q;  end
      ST_GAP:  begin alu_op = OP_SUB; alu_a = z_q;   alu_b = ang_q;  end
      ST_M1:   begin alu_op = OP_MUL; alu_a = k0_q;  alu_b = gap_q;  end
      ST_ANG2: begin alu_op = OP_ADD; alu_a = ang_q; alu_b = m_q;    end
      ST_M2:   begin alu_op = OP_MUL; alu_a = k1_q;  alu_b = gap_q;  end
      ST_BIAS: begin alu_op = OP_ADD; alu_a = bias_q; alu_b = m_q;   end
      ST_M3:   begin alu_op = OP_MUL; alu_a = k0_q;  alu_b = p00_q;  end
      ST_M4:   begin alu_op = OP_MUL; alu_a = k0_q;  alu_b = p01_q;  end
      ST_M5:   begin alu_op = OP_MUL; alu_a = k1_q;  alu_b = p00_q;  end
      ST_M6:   begin alu_op = OP_MUL; alu_a = k1_q;  alu_b = p01_q;  end
      ST_P00B: begin alu_op = OP_SUB; alu_a = p00_q; alu_b = m_q;    end
      ST_P01B: begin alu_op = OP_SUB; alu_a = p01_q; alu_b = tmp_q;  end
      ST_P10B: begin alu_op = OP_SUB; alu_a = p10_q; alu_b = gap_q;  end
      ST_P11B: begin alu_op = OP_SUB; alu_a = p11_q; alu_b = k0_q;   end
      default: ;
    endcase

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          z_d = measured_angle_i;
          w_d = measured_rate_i;
          dt_d = val_t'({1'b0, time_step_i});
          sat_d = 1'b0;
          if (force_angle_i) begin
            ang_d = measured_angle_i;
            state_d = ST_OUT;
          end else begin
            state_d = ST_RATE;
            busy_d = 1'b0;
          end
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d = ang_q;
          out_sat_d = sat_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        // issue once, then wait for the unit
        if (!busy_q) begin
          alu_start = 1'b1;
          busy_d = 1'b1;
        end else if (alu_done) begin
          busy_d = 1'b0;
          sat_d = sat_q | alu_sat;
          state_d = seq_state_e'(state_q + 6'd1);
          case (state_q)
            ST_RATE, ST_T1, ST_T2, ST_T3, ST_T4, ST_D, ST_S, ST_M4: tmp_d = alu_res;
            ST_MDR, ST_T5, ST_QB, ST_M1, ST_M2, ST_M3: m_d = alu_res;
            ST_ANG1, ST_ANG2: ang_d = alu_res;
            ST_P00A, ST_P00B: p00_d = alu_res;
            ST_P01A, ST_P01B: p01_d = alu_res;
            ST_P10A, ST_P10B: p10_d = alu_res;
            ST_P11A, ST_P11B: p11_d = alu_res;
            ST_K0, ST_M6: k0_d = alu_res;
            ST_K1: k1_d = alu_res;
            ST_GAP, ST_M5: gap_d = alu_res;
            ST_BIAS: bias_d = alu_res;
            default: ;
          endcase
          if (state_q == ST_S && alu_res == '0) begin
            // zero innovation variance: gains are zero
            k0_d = '0;
            k1_d = '0;
            state_d = ST_GAP;
          end
          if (state_q == ST_P11B) begin
            state_d = ST_OUT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
      ang_q <= '0;
      bias_q <= '0;
      p00_q <= '0;
      p01_q <= '0;
      p10_q <= '0;
      p11_q <= '0;
      sat_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q <= busy_d;
      out_valid_q <= out_valid_d;
      ang_q <= ang_d;
      bias_q <= bias_d;
      p00_q <= p00_d;
      p01_q <= p01_d;
      p10_q <= p10_d;
      p11_q <= p11_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q <= z_d;
    w_q <= w_d;
    dt_q <= dt_d;
    tmp_q <= tmp_d;
    m_q <= m_d;
    k0_q <= k0_d;
    k1_q <= k1_d;
    gap_q <= gap_d;
    out_q <= out_d;
    out_sat_q <= out_sat_d;
  end

endmodule

`default_nettype wire

/* bench/kalman_angle_filter_tb.sv */
// ----------------------------------------------------------------------------
// kalman_angle_filter_tb: self-checking bench of the angle kalman filter
// drives measurement beats with bursty gaps against a stalling receiver,
// predicts each filtered angle in fixed point and checks every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kalman_angle_filter_tb;
  import kaf_pkg::*;

  localparam int DW = DataWidthDef;
  localparam int FB = FracBitsDef;
  localparam int CycleLimit = 2000000;
  localparam int RandPerPhase = 200;
  localparam int HoldCycles = 2000;

  localparam logic signed [DW-1:0] AngMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] AngMin = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] One = 48'sh1_0000_0000;
  localparam logic [DW-2:0] DtMax = {(DW-1){1'b1}};
  localparam logic [DW-2:0] DtMilli = 47'd4294967;
  localparam logic [DW-2:0] QAngleDef = 47'd4294967;
  localparam logic [DW-2:0] QBiasDef = 47'd12884902;
  localparam logic [DW-2:0] RMeasDef = 47'd128849019;

  typedef struct packed {
    logic signed [DW-1:0] ang;
    logic signed [DW-1:0] rate;
    logic [DW-2:0]        dt;
    logic                 force_ang;
    logic                 typed;
    logic signed [DW-1:0] exp_ang;
    logic                 exp_sat;
  } dir_row_t;

  typedef struct packed {
    logic signed [DW-1:0] ang;
    logic                 sat;
  } angle_res_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [63:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [DW-1:0] measured_angle_i, measured_rate_i, filtered_angle_o;
  logic [DW-2:0] time_step_i;
  logic force_angle_i, saturated_o;

  kalman_angle_filter u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .measured_angle_i, .measured_rate_i, .time_step_i,
    .force_angle_i, .out_valid_o, .out_ready_i, .filtered_angle_o, .saturated_o
  );

  // predictor state and register copies
  logic signed [DW-1:0] pr_angle, pr_bias;
  logic signed [DW-1:0] pr_cov [4];
  logic signed [DW-1:0] pr_qa, pr_qb, pr_r;
  logic pr_sat;

  angle_res_t angle_q[$];
  int n_sent, n_checked, n_err, n_cfg, cyc;
  logic hold_go, hold_done;
  int hold_cnt, rx_mode, rx_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [DW-1:0] clamp(input logic signed [127:0] v);
    logic signed [127:0] hi, lo;
    hi = AngMax;
    lo = AngMin;
    if (v > hi) begin
      pr_sat = 1'b1;
      return AngMax;
    end
    if (v < lo) begin
      pr_sat = 1'b1;
      return AngMin;
    end
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a, b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return clamp(x + y);
  endfunction

  function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a, b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return clamp(x - y);
  endfunction

  // product floored by the arithmetic shift
  function automatic logic signed [DW-1:0] smul(input logic signed [DW-1:0] a, b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return clamp((x * y) >>> FB);
  endfunction

  // signed division truncates toward zero
  function automatic logic signed [DW-1:0] sdiv(input logic signed [DW-1:0] a, b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    if (b == 0) return '0;
    x = x <<< FB;
    return clamp(x / y);
  endfunction

  function automatic angle_res_t filter_step(input logic signed [DW-1:0] z, w,
                                             input logic [DW-2:0] dt_u,
                                             input logic force_ang);
    logic signed [DW-1:0] dt, rate, t, d, s, k0, k1, gap, p00, p01;
    angle_res_t r;
    dt = {1'b0, dt_u};
    pr_sat = 1'b0;
    if (force_ang) begin
      pr_angle = z;
      r.ang = z;
      r.sat = 1'b0;
      return r;
    end
    rate = ssub(w, pr_bias);
    pr_angle = sadd(pr_angle, smul(dt, rate));
    t = smul(dt, pr_cov[3]);
    t = ssub(t, pr_cov[1]);
    t = ssub(t, pr_cov[2]);
    t = sadd(t, pr_qa);
    pr_cov[0] = sadd(pr_cov[0], smul(dt, t));
    d = smul(dt, pr_cov[3]);
    pr_cov[1] = ssub(pr_cov[1], d);
    pr_cov[2] = ssub(pr_cov[2], d);
    pr_cov[3] = sadd(pr_cov[3], smul(pr_qb, dt));
    s = sadd(pr_cov[0], pr_r);
    k0 = '0;
    k1 = '0;
    if (s != 0) begin
      k0 = sdiv(pr_cov[0], s);
      k1 = sdiv(pr_cov[2], s);
    end
    gap = ssub(z, pr_angle);
    pr_angle = sadd(pr_angle, smul(k0, gap));
    pr_bias = sadd(pr_bias, smul(k1, gap));
    p00 = pr_cov[0];
    p01 = pr_cov[1];
    pr_cov[0] = ssub(pr_cov[0], smul(k0, p00));
    pr_cov[1] = ssub(pr_cov[1], smul(k0, p01));
    pr_cov[2] = ssub(pr_cov[2], smul(k1, p00));
    pr_cov[3] = ssub(pr_cov[3], smul(k1, p01));
    r.ang = pr_angle;
    r.sat = pr_sat;
    return r;
  endfunction

  // one beat into the block; payload changes only at acceptance
  task automatic send_beat(input logic signed [DW-1:0] z, w, input logic [DW-2:0] dt,
                           input logic force_ang, input logic typed,
                           input angle_res_t typed_res);
    angle_res_t r;
    in_valid_i <= 1'b1;
    measured_angle_i <= z;
    measured_rate_i <= w;
    time_step_i <= dt;
    force_angle_i <= force_ang;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = filter_step(z, w, dt, force_ang);
    angle_q.push_back(typed ? typed_res : r);
    n_sent++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DW-2:0] val);
    in_valid_i <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= {17'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegQAngle: pr_qa = {1'b0, val};
      RegQBias:  pr_qb = {1'b0, val};
      RegRMeas:  pr_r  = {1'b0, val};
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_noise(input logic [DW-2:0] qa, qb, r);
    reg_write(RegQAngle, qa);
    reg_write(RegQBias, qb);
    reg_write(RegRMeas, r);
  endtask

  function automatic logic signed [DW-1:0] rand_full();
    return DW'({$urandom(), $urandom()});
  endfunction

  function automatic logic signed [DW-1:0] rand_q(input int lim);
    logic signed [DW-1:0] v;
    v = $signed($urandom_range(0, 2 * lim)) - lim;
    return (v <<< FB) | {16'd0, $urandom()};
  endfunction

  task automatic random_phase(input int n);
    int burst;
    logic signed [DW-1:0] z, w;
    logic [DW-2:0] dt;
    logic f;
    angle_res_t none;
    none = '0;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise across every bit of every field
        z = rand_full();
        w = rand_full();
        dt = (DW-1)'({$urandom(), $urandom()});
        f = 1'($urandom_range(0, 1));
      end else begin
        z = rand_q(180);
        w = rand_q(500);
        dt = $urandom_range(0, 3) == 0 ? 47'($urandom_range(0, 1 << 26)) : DtMilli;
        f = $urandom_range(0, 19) == 0;
      end
      send_beat(z, w, dt, f, 1'b0, none);
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 400));
      end else begin
        burst--;
      end
    end
  endtask

  // receiver: stall pattern in modes, plus one long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
      rx_mode <= 0;
      rx_left <= 0;
    end else if (hold_cnt > 0) begin
      out_ready_i <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_cnt <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(50, 2000);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    angle_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angle_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat: angle %h sat %b",
                                  filtered_angle_o, saturated_o);
      end else begin
        e = angle_q.pop_front();
        n_checked++;
        if (filtered_angle_o !== e.ang || saturated_o !== e.sat) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch at beat %0d: angle exp %h got %h, sat exp %b got %b",
                     n_checked, e.ang, filtered_angle_o, e.sat, saturated_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("timeout with %0d results outstanding", angle_q.size());
      $display("kalman_angle_filter_tb failed");
      $finish;
    end
  end

  dir_row_t dir_tab [14];

  initial begin
    angle_res_t tr;
    dir_tab = '{
      '{AngMax, 48'sd0, 47'd0, 1'b1, 1'b1, AngMax, 1'b0},
      '{AngMin, 48'sd0, 47'd0, 1'b1, 1'b1, AngMin, 1'b0},
      '{48'sd0, AngMax, DtMax, 1'b1, 1'b1, 48'sd0, 1'b0},
      '{90 * One, 10 * One, DtMilli, 1'b0, 1'b0, 48'sd0, 1'b0},
      '{AngMax, AngMax, DtMax, 1'b0, 1'b0, 48'sd0, 1'b0},
      '{AngMin, AngMin, DtMax, 1'b0, 1'b0, 48'sd0, 1'b0},
      '{AngMax, AngMin, 47'd1, 1'b0, 1'b0, 48'sd0, 1'b0},
      '{AngMin, AngMax, One[DW-2:0], 1'b0, 1'b0, 48'sd0, 1'b0},
      '{48'sd0, 48'sd0, 47'd0, 1'b0, 1'b0, 48'sd0, 1'b0},
      '{-One, -One, One[DW-2:0], 1'b0, 1'b0, 48'sd0, 1'b0},
      '{48'sd12345, -5 * One, DtMax, 1'b1, 1'b1, 48'sd12345, 1'b0},
      '{30 * One, 2 * One, DtMilli, 1'b0, 1'b0, 48'sd0, 1'b0},
      '{-45 * One, -3 * One, DtMilli, 1'b0, 1'b0, 48'sd0, 1'b0},
      '{48'sd1, -48'sd1, 47'd1, 1'b0, 1'b0, 48'sd0, 1'b0}
    };
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    measured_angle_i = '0;
    measured_rate_i = '0;
    time_step_i = '0;
    force_angle_i = 1'b0;
    hold_go = 1'b0;
    n_sent = 0;
    n_checked = 0;
    n_err = 0;
    n_cfg = 0;
    pr_angle = '0;
    pr_bias = '0;
    for (int i = 0; i < 4; i++) pr_cov[i] = '0;
    pr_qa = {1'b0, QAngleDef};
    pr_qb = {1'b0, QBiasDef};
    pr_r = {1'b0, RMeasDef};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero angle and measurement noise on a cleared covariance: the first step has zero innovation variance, gains zero
    tr = '0;
    reg_write(RegQAngle, '0);
    reg_write(RegRMeas, '0);
    send_beat(20 * One, 7 * One, DtMilli, 1'b0, 1'b0, tr);
    send_beat(-20 * One, AngMax, DtMax, 1'b0, 1'b0, tr);
    drain();
    set_noise(QAngleDef, QBiasDef, RMeasDef);

    foreach (dir_tab[i]) begin
      tr.ang = dir_tab[i].exp_ang;
      tr.sat = dir_tab[i].exp_sat;
      send_beat(dir_tab[i].ang, dir_tab[i].rate, dir_tab[i].dt, dir_tab[i].force_ang,
                dir_tab[i].typed, tr);
      idle_gap($urandom_range(0, 2));
    end
    drain();

    random_phase(RandPerPhase);
    drain();
    // long receiver hold while beats keep coming
    hold_go = 1'b1;
    set_noise('0, '0, '0);
    random_phase(RandPerPhase);
    drain();
    set_noise(DtMax, DtMax, DtMax);
    random_phase(RandPerPhase / 2);
    drain();
    set_noise(47'd1, 47'd1, 47'd1);
    random_phase(RandPerPhase / 2);
    drain();
    set_noise(47'($urandom_range(0, 1 << 24)), 47'($urandom_range(0, 1 << 25)),
              47'($urandom_range(0, 1 << 29)));
    random_phase(RandPerPhase);
    drain();
    set_noise(QAngleDef, QBiasDef, RMeasDef);
    random_phase(RandPerPhase);
    drain();

    $display("sent %0d measurement beats, checked %0d results, %0d register writes",
             n_sent, n_checked, n_cfg);
    $display("noise settings: default, zero, maximum, minimum nonzero, random");
    if (n_err == 0 && angle_q.size() == 0) begin
      $display("kalman_angle_filter_tb passed");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, angle_q.size());
      $display("kalman_angle_filter_tb failed");
    end
    $finish;
  end

endmodule
